// ----- hdl/oss_pkg.sv -----
`default_nettype none

package oss_pkg;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;
   localparam int DT_W       = 17;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_MIN = 1'b0,
      CSR_STEP_MAX = 1'b1
   } csr_index_type;

   localparam logic [DT_W-1:0] STEP_MIN_RESET = 17'd1;
   localparam logic [DT_W-1:0] STEP_MAX_RESET = 17'd65536;

   localparam logic signed [65:0] ONE_Q32 = 66'sd4294967296;
   localparam logic signed [65:0] SAT_HI  = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO  = -66'sd2147483648;

   typedef struct packed {
      logic        [7:0]  series_index;
      logic               seq_start;
      logic signed [31:0] stiffness;
      logic signed [31:0] damping;
      logic signed [31:0] raw_step;
      logic signed [31:0] drive_real;
      logic signed [31:0] drive_imag;
   } req_type;

   typedef struct packed {
      logic        [7:0]  out_series;
      logic signed [31:0] vel_real;
      logic signed [31:0] vel_imag;
      logic signed [31:0] pos_real;
      logic signed [31:0] pos_imag;
   } rsp_type;

   // one store word: imaginary part in the upper half
   typedef struct packed {
      logic signed [31:0] im;
      logic signed [31:0] re;
   } cplx_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > SAT_HI) begin
         return SAT_HI[31:0];
      end else if (v < SAT_LO) begin
         return SAT_LO[31:0];
      end else begin
         return signed'(v[31:0]);
      end
   endfunction

endpackage

`default_nettype wire

// ----- hdl/oss_chan_if.sv -----
`default_nettype none

interface oss_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/oss_state_mem.sv -----
`default_nettype none

module oss_state_mem #(
   parameter int SERIES = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(SERIES > 1 ? $clog2(SERIES) : 1)-1:0] wr_addr,
   input  wire oss_pkg::cplx_type                      wr_vel,
   input  wire oss_pkg::cplx_type                      wr_pos,
   input  wire logic                                   rd_en,
   input  wire logic [(SERIES > 1 ? $clog2(SERIES) : 1)-1:0] rd_addr,
   output oss_pkg::cplx_type                           rd_vel,
   output oss_pkg::cplx_type                           rd_pos
);

   oss_pkg::cplx_type vel_mem [SERIES];
   oss_pkg::cplx_type pos_mem [SERIES];
   oss_pkg::cplx_type rd_vel_ff;
   oss_pkg::cplx_type rd_pos_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vel_mem[wr_addr] <= wr_vel;
         pos_mem[wr_addr] <= wr_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_vel_ff <= vel_mem[rd_addr];
         rd_pos_ff <= pos_mem[rd_addr];
      end
   end

   assign rd_vel = rd_vel_ff;
   assign rd_pos = rd_pos_ff;

endmodule

`default_nettype wire

// ----- hdl/oss_step_dp.sv -----
`default_nettype none

// Free-running stages; the held item and read data stay put while the
// sequencer walks the stages, so each stage is valid in the cycle after the last.
module oss_step_dp #(
   parameter int SERIES = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   load,
   input  wire oss_pkg::req_type                       req_item,
   input  wire logic [oss_pkg::DT_W-1:0]               step_min,
   input  wire logic [oss_pkg::DT_W-1:0]               step_max,
   input  wire oss_pkg::cplx_type                      mem_vel,
   input  wire oss_pkg::cplx_type                      mem_pos,
   output logic [(SERIES > 1 ? $clog2(SERIES) : 1)-1:0] slot,
   output oss_pkg::rsp_type                            result
);

   localparam int IdxW = (SERIES > 1) ? $clog2(SERIES) : 1;

   oss_pkg::req_type          item_ff;
   logic [oss_pkg::DT_W-1:0]  dt_ff, dt_in;
   logic signed [17:0]        dts;

   oss_pkg::cplx_type   w_ff, w_in, x_ff, x_in;
   logic signed [63:0]  ax_re_ff, ax_re_in, ax_im_ff, ax_im_in;
   logic signed [49:0]  dg_ff, dg_in;
   logic signed [31:0]  comb_re_ff, comb_re_in, comb_im_ff, comb_im_in;
   logic signed [31:0]  alpha_ff, alpha_in;
   logic signed [49:0]  p_re_ff, p_re_in, p_im_ff, p_im_in;
   logic signed [63:0]  aw_re_ff, aw_re_in, aw_im_ff, aw_im_in;
   logic signed [51:0]  t_re_ff, t_re_in, t_im_ff, t_im_in;
   oss_pkg::cplx_type   wn_ff, wn_in;
   oss_pkg::cplx_type   xn;
   logic [IdxW-1:0]     slot_tab [256];

   // step clamp, lower bound first so inverted bounds give step_max
   always_comb begin
      logic signed [32:0] raw_x;
      logic signed [32:0] lo_x;
      logic signed [32:0] hi_x;
      logic signed [32:0] c1;
      logic signed [32:0] c2;
      raw_x = 33'(req_item.raw_step);
      lo_x  = signed'({16'd0, step_min});
      hi_x  = signed'({16'd0, step_max});
      c1    = (raw_x < lo_x) ? lo_x : raw_x;
      c2    = (c1 > hi_x) ? hi_x : c1;
      dt_in = c2[oss_pkg::DT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
         dt_ff   <= dt_in;
      end
   end

   assign dts = signed'({1'b0, dt_ff});

   // series index modulo SERIES, a constant table over the 8-bit index
   for (genvar i = 0; i < 256; i++) begin : g_slot
      assign slot_tab[i] = IdxW'(i % SERIES);
   end

   assign slot = slot_tab[item_ff.series_index];

   // products of the old state, and step times damping
   always_comb begin
      w_in     = item_ff.seq_start ? '0 : mem_vel;
      x_in     = item_ff.seq_start ? '0 : mem_pos;
      ax_re_in = item_ff.stiffness * x_in.re;
      ax_im_in = item_ff.stiffness * x_in.im;
      dg_in    = dts * item_ff.damping;
   end

   // drive minus restoring force, and damping factor
   always_comb begin
      comb_re_in = oss_pkg::sat32(66'(item_ff.drive_real) - 66'(ax_re_ff >>> 16));
      comb_im_in = oss_pkg::sat32(66'(item_ff.drive_imag) - 66'(ax_im_ff >>> 16));
      alpha_in   = oss_pkg::sat32((oss_pkg::ONE_Q32 - 66'(dg_ff)) >>> 16);
   end

   always_comb begin
      p_re_in  = dts * comb_re_ff;
      p_im_in  = dts * comb_im_ff;
      aw_re_in = alpha_ff * w_ff.re;
      aw_im_in = alpha_ff * w_ff.im;
   end

   always_comb begin
      t_re_in = 34'(p_re_ff >>> 16) * dts;
      t_im_in = 34'(p_im_ff >>> 16) * dts;
   end

   always_comb begin
      wn_in.re = oss_pkg::sat32((66'(aw_re_ff) + 66'(t_re_ff)) >>> 16);
      wn_in.im = oss_pkg::sat32((66'(aw_im_ff) + 66'(t_im_ff)) >>> 16);
   end

   always_ff @(posedge clock) begin
      w_ff       <= w_in;
      x_ff       <= x_in;
      ax_re_ff   <= ax_re_in;
      ax_im_ff   <= ax_im_in;
      dg_ff      <= dg_in;
      comb_re_ff <= comb_re_in;
      comb_im_ff <= comb_im_in;
      alpha_ff   <= alpha_in;
      p_re_ff    <= p_re_in;
      p_im_ff    <= p_im_in;
      aw_re_ff   <= aw_re_in;
      aw_im_ff   <= aw_im_in;
      t_re_ff    <= t_re_in;
      t_im_ff    <= t_im_in;
      wn_ff      <= wn_in;
   end

   always_comb begin
      xn.re = oss_pkg::sat32(66'(x_ff.re) + 66'(wn_ff.re));
      xn.im = oss_pkg::sat32(66'(x_ff.im) + 66'(wn_ff.im));
      result.out_series = item_ff.series_index;
      result.vel_real   = wn_ff.re;
      result.vel_imag   = wn_ff.im;
      result.pos_real   = xn.re;
      result.pos_imag   = xn.im;
   end

endmodule

`default_nettype wire

// ----- hdl/oscillator_ssm_forward_scan.sv -----
// Damped oscillator scan step over many interleaved series.
// req_ch (valid/ready) carries one time step: series index, start flag,
// stiffness, damping, raw step and complex drive. rsp_ch returns one item
// per step: the series index with new velocity and position, saturated.
// csr_we/csr_index/csr_wdata write the step clamp bounds (index 0 lower,
// index 1 upper); write them only while no item is in flight.
// Velocity and position live in two single-port-read memories, one entry
// per series. An item is read, run through a five-stage multiply chain and
// written back before the next is taken, so the same series may follow
// itself without hazard.
// Each item steps through the read, five arithmetic stages and write-back,
// and its result is then held in the output register.
// The output register frees the pipe: the next item is taken while a result
// waits; a further result then holds in write-back until rsp_ch drains.
// Reset: bounds go to 1 and 65536, sequencer to idle, output empty. The
// stores are not cleared; a series must start with seq_start set.
`default_nettype none

module oscillator_ssm_forward_scan #(
   parameter int SERIES = 256
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   oss_chan_if.sink                              req_ch,
   oss_chan_if.source                            rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [oss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [oss_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IdxW = (SERIES > 1) ? $clog2(SERIES) : 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_PROD, ST_COMB, ST_SCALE, ST_DRIVE, ST_SUM, ST_WB
   } state_type;

   state_type                 state_ff;
   logic                      rsp_valid_ff;
   oss_pkg::rsp_type          rsp_payload_ff;
   logic [oss_pkg::DT_W-1:0]  step_min_ff;
   logic [oss_pkg::DT_W-1:0]  step_max_ff;

   logic                      accept;
   logic                      wb_fire;
   logic [IdxW-1:0]           slot;
   oss_pkg::rsp_type          result;
   oss_pkg::cplx_type         mem_vel;
   oss_pkg::cplx_type         mem_pos;
   oss_pkg::cplx_type         wr_vel;
   oss_pkg::cplx_type         wr_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_min_ff <= oss_pkg::STEP_MIN_RESET;
         step_max_ff <= oss_pkg::STEP_MAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            oss_pkg::CSR_STEP_MIN: step_min_ff <= csr_wdata;
            oss_pkg::CSR_STEP_MAX: step_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE) && !reset;
   assign accept       = req_ch.valid && req_ch.ready;
   assign wb_fire      = (state_ff == ST_WB) && (!rsp_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE:  if (accept) state_ff <= ST_READ;
            ST_READ:  state_ff <= ST_PROD;
            ST_PROD:  state_ff <= ST_COMB;
            ST_COMB:  state_ff <= ST_SCALE;
            ST_SCALE: state_ff <= ST_DRIVE;
            ST_DRIVE: state_ff <= ST_SUM;
            ST_SUM:   state_ff <= ST_WB;
            ST_WB:    if (wb_fire) state_ff <= ST_IDLE;
            default:  state_ff <= ST_IDLE;
         endcase
         if (wb_fire) begin
            rsp_valid_ff   <= 1'b1;
            rsp_payload_ff <= result;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload_ff;

   assign wr_vel.re = result.vel_real;
   assign wr_vel.im = result.vel_imag;
   assign wr_pos.re = result.pos_real;
   assign wr_pos.im = result.pos_imag;

   oss_step_dp #(.SERIES(SERIES)) u_dp (
      .clock    (clock),
      .load     (accept),
      .req_item (req_ch.payload),
      .step_min (step_min_ff),
      .step_max (step_max_ff),
      .mem_vel  (mem_vel),
      .mem_pos  (mem_pos),
      .slot     (slot),
      .result   (result)
   );

   oss_state_mem #(.SERIES(SERIES)) u_mem (
      .clock   (clock),
      .wr_en   (wb_fire),
      .wr_addr (slot),
      .wr_vel  (wr_vel),
      .wr_pos  (wr_pos),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (slot),
      .rd_vel  (mem_vel),
      .rd_pos  (mem_pos)
   );

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_READ)
      else $error("accepted item did not start a store read");

   a_rsp_from_wb: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(state_ff) == ST_WB)
      else $error("result appeared without a write-back");

   a_wb_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WB) && rsp_ch.valid && !rsp_ch.ready |=> state_ff == ST_WB)
      else $error("write-back left while the output was full");

   a_wb_shows: assert property (@(posedge clock) disable iff (reset)
      wb_fire |=> rsp_ch.valid && req_ch.ready)
      else $error("write-back did not present a result");

endmodule

`default_nettype wire
